// ===== rtl/sbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, sizes and helpers of the sprite blitter with collision check.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 4;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int SPRITE_W    = 8;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int K_W    = $clog2(SPRITE_W);

	// widths of the item fields
	localparam int OP_W   = 2;
	localparam int X_W    = 7;
	localparam int Y_W    = 5;
	localparam int PG_W   = 2;
	localparam int BYTE_W = 8;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	typedef logic [SPRITE_W-1:0][BYTE_W-1:0] sprite_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_LO,
		S_WR_LO,
		S_RD_HI,
		S_WR_HI,
		S_RD_BYTE,
		S_RD_DATA,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [PAGE_W-1:0] pg,
		input logic [COL_W-1:0]  col
	);
		store_addr = ADDR_W'(ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sbc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_store
// Single-port frame store, one byte per access, registered read data.
// ----------------------------------------------------------------------------
module sbc_store
	import sbc_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/sbc_blit_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_blit_unit
// Shared column unit: picks one sprite column, shifts it into its page
// position and checks it against the stored byte for overlap.
// ----------------------------------------------------------------------------
module sbc_blit_unit
	import sbc_pkg::*;
(
	input  wire sprite_t           cols,
	input  wire logic [K_W-1:0]    k,
	input  wire logic [2:0]        shift,
	input  wire logic              sel_hi,
	input  wire logic [BYTE_W-1:0] old_byte,
	output logic      [BYTE_W-1:0] new_byte,
	output logic                   overlap
);

	logic [2*BYTE_W-1:0] spread;

	always_comb begin
		spread   = {{BYTE_W{1'b0}}, cols[k]} << shift;
		new_byte = sel_hi ? spread[2*BYTE_W-1:BYTE_W] : spread[BYTE_W-1:0];
		overlap  = |(old_byte & new_byte);
	end

endmodule
`default_nettype wire

// ===== rtl/sbc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_seq
// Sequencer: clearing sweep, per-column read-modify-write for draws,
// single byte reads, and the result strobe.
// ----------------------------------------------------------------------------
module sbc_seq
	import sbc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [X_W-1:0]    x,
	input  wire logic [Y_W-1:0]    y,
	input  wire logic [PG_W-1:0]   page,
	input  wire sprite_t           sprite,
	input  wire logic [BYTE_W-1:0] rdata,
	output mem_req_t               req,
	output logic                   busy,
	output logic                   result_valid,
	output logic                   collision,
	output logic                   off_screen,
	output logic [BYTE_W-1:0]      read_data
);

	state_t state_q, state_nxt;

	logic [ADDR_W-1:0] clr_q;
	logic              item_q;
	logic [X_W-1:0]    x_q;
	logic [PAGE_W-1:0] top_q;
	logic [PAGE_W-1:0] bot_q;
	logic [PAGE_W-1:0] page_q;
	logic [2:0]        shift_q;
	logic [K_W-1:0]    k_q;
	sprite_t           cols_q;
	logic              coll_q;
	logic              off_q;
	logic [BYTE_W-1:0] rd_q;

	logic              accept;
	logic [Y_W-2:0]    bot_full;
	logic              bot_off;
	logic              x_off;
	logic              rd_ok;
	logic [X_W:0]      cur_col;
	logic [X_W:0]      nxt_col;
	logic              last_col;
	logic              two_page;
	logic              sel_hi;
	logic [BYTE_W-1:0] new_byte;
	logic              overlap;

	sbc_blit_unit u_unit (
		.cols     (cols_q),
		.k        (k_q),
		.shift    (shift_q),
		.sel_hi   (sel_hi),
		.old_byte (rdata),
		.new_byte (new_byte),
		.overlap  (overlap)
	);

	always_comb begin
		accept   = start && (state_q == S_IDLE);
		bot_full = (Y_W-1)'(({1'b0, y} + (Y_W+1)'(SPRITE_W - 1)) >> 3);
		bot_off  = int'(bot_full) >= PAGES;
		x_off    = int'(x) >= COLUMNS;
		rd_ok    = (int'(page) < PAGES) && (int'(x) < COLUMNS);
		cur_col  = {1'b0, x_q} + (X_W+1)'(k_q);
		nxt_col  = cur_col + (X_W+1)'(1);
		last_col = (k_q == K_W'(SPRITE_W - 1)) || (int'(nxt_col) >= COLUMNS);
		two_page = shift_q != 3'd0;
		sel_hi   = (state_q == S_WR_HI);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_nxt = item_q ? S_RESULT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_CLEAR: state_nxt = S_CLEAR;
						OP_DRAW:  state_nxt = (bot_off || x_off) ? S_RESULT : S_RD_LO;
						OP_READ:  state_nxt = rd_ok ? S_RD_BYTE : S_RESULT;
						default:  state_nxt = S_RESULT;
					endcase
				end
			end
			S_RD_LO:   state_nxt = S_WR_LO;
			S_WR_LO: begin
				if (two_page) begin
					state_nxt = S_RD_HI;
				end else begin
					state_nxt = last_col ? S_RESULT : S_RD_LO;
				end
			end
			S_RD_HI:   state_nxt = S_WR_HI;
			S_WR_HI:   state_nxt = last_col ? S_RESULT : S_RD_LO;
			S_RD_BYTE: state_nxt = S_RD_DATA;
			S_RD_DATA: state_nxt = S_RESULT;
			S_RESULT:  state_nxt = S_IDLE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		req          = '0;
		busy         = (state_q != S_IDLE);
		result_valid = (state_q == S_RESULT);
		case (state_q)
			S_CLEAR: begin
				req.we   = 1'b1;
				req.addr = clr_q;
			end
			S_RD_LO: req.addr = store_addr(top_q, cur_col[COL_W-1:0]);
			S_WR_LO: begin
				req.we    = 1'b1;
				req.addr  = store_addr(top_q, cur_col[COL_W-1:0]);
				req.wdata = new_byte;
			end
			S_RD_HI: req.addr = store_addr(bot_q, cur_col[COL_W-1:0]);
			S_WR_HI: begin
				req.we    = 1'b1;
				req.addr  = store_addr(bot_q, cur_col[COL_W-1:0]);
				req.wdata = new_byte;
			end
			S_RD_BYTE: req.addr = store_addr(page_q, x_q[COL_W-1:0]);
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			item_q  <= 1'b0;
			k_q     <= '0;
			coll_q  <= 1'b0;
			off_q   <= 1'b0;
			rd_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept) begin
				item_q <= 1'b1;
				clr_q  <= '0;
				k_q    <= '0;
				coll_q <= (operation == OP_DRAW) && bot_off;
				off_q  <= (operation == OP_DRAW) && bot_off;
				rd_q   <= '0;
			end
			if ((state_q == S_WR_LO) || (state_q == S_WR_HI)) begin
				if (overlap) begin
					coll_q <= 1'b1;
				end
				// advance once the last byte of this column is written
				if ((state_q == S_WR_HI) || !two_page) begin
					k_q <= k_q + K_W'(1);
				end
			end
			if (state_q == S_RD_DATA) begin
				rd_q <= rdata;
			end
		end
	end

	// item fields, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x;
			top_q   <= PAGE_W'(y >> 3);
			bot_q   <= PAGE_W'(bot_full);
			page_q  <= PAGE_W'(page);
			shift_q <= y[2:0];
			cols_q  <= sprite;
		end
	end

	assign collision  = coll_q;
	assign off_screen = off_q;
	assign read_data  = rd_q;

endmodule
`default_nettype wire

// ===== rtl/sprite_blit_collision_page_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_blit_collision_page_buffer
// Page-organized monochrome frame store with an 8x8 sprite blitter that
// reports pixel collisions, a store clear and a single byte read.
//
//   channel  handshake              fields
//   -------  ---------------------  -----------------------------------------
//   command  start / busy           operation x y page sprite_col0..7
//   result   result_valid (strobe)  collision off_screen read_data
//
// A draw does one read and one write per sprite column on one page and two
// of each when the column spans two pages (one read and one write per byte on
// the single memory port), then gives the result. A read fetches one byte
// and then gives the result; a clear writes every stored byte (512) first.
// After reset the store is swept to zero, all 512 bytes, with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sprite_blit_collision_page_buffer
	import sbc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [X_W-1:0]    x,
	input  wire logic [Y_W-1:0]    y,
	input  wire logic [PG_W-1:0]   page,
	input  wire logic [BYTE_W-1:0] sprite_col0,
	input  wire logic [BYTE_W-1:0] sprite_col1,
	input  wire logic [BYTE_W-1:0] sprite_col2,
	input  wire logic [BYTE_W-1:0] sprite_col3,
	input  wire logic [BYTE_W-1:0] sprite_col4,
	input  wire logic [BYTE_W-1:0] sprite_col5,
	input  wire logic [BYTE_W-1:0] sprite_col6,
	input  wire logic [BYTE_W-1:0] sprite_col7,
	output logic                   result_valid,
	output logic                   collision,
	output logic                   off_screen,
	output logic [BYTE_W-1:0]      read_data
);

	sprite_t           sprite;
	mem_req_t          req;
	logic [BYTE_W-1:0] rdata;

	assign sprite = {sprite_col7, sprite_col6, sprite_col5, sprite_col4,
	                 sprite_col3, sprite_col2, sprite_col1, sprite_col0};

	sbc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.x            (x),
		.y            (y),
		.page         (page),
		.sprite       (sprite),
		.rdata        (rdata),
		.req          (req),
		.busy         (busy),
		.result_valid (result_valid),
		.collision    (collision),
		.off_screen   (off_screen),
		.read_data    (read_data)
	);

	sbc_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule
`default_nettype wire

// ===== tb/sprite_blit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_checker
// Watches the command and result channels of the sprite blitter. It keeps its
// own copy of the frame store, works out the result of every accepted command
// and compares each result strobe with the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module sprite_blit_checker
	import sbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [OP_W-1:0]   operation,
	input  logic [X_W-1:0]    x,
	input  logic [Y_W-1:0]    y,
	input  logic [PG_W-1:0]   page,
	input  logic [BYTE_W-1:0] sprite_col0,
	input  logic [BYTE_W-1:0] sprite_col1,
	input  logic [BYTE_W-1:0] sprite_col2,
	input  logic [BYTE_W-1:0] sprite_col3,
	input  logic [BYTE_W-1:0] sprite_col4,
	input  logic [BYTE_W-1:0] sprite_col5,
	input  logic [BYTE_W-1:0] sprite_col6,
	input  logic [BYTE_W-1:0] sprite_col7,
	input  logic              result_valid,
	input  logic              collision,
	input  logic              off_screen,
	input  logic [BYTE_W-1:0] read_data,
	output int                mismatch_count,
	output int                outstanding
);

	typedef struct packed {
		logic              hit;
		logic              off;
		logic [BYTE_W-1:0] data;
	} blit_outcome_t;

	logic [BYTE_W-1:0] pixels [PAGES][COLUMNS];
	blit_outcome_t     awaited [$];

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns  mismatch: %s", $realtime, msg);
	endtask

	// applies one command to the shadow store and returns its outcome
	task automatic blit_predict(
		input  logic [OP_W-1:0] op,
		input  logic [X_W-1:0]  col_x,
		input  logic [Y_W-1:0]  row_y,
		input  logic [PG_W-1:0] pg,
		input  sprite_t         cols,
		output blit_outcome_t   res
	);
		int          top_pg;
		int          bot_pg;
		int          col;
		logic [15:0] spread;
		res = '0;
		case (op)
			OP_CLEAR: begin
				foreach (pixels[p, c])
					pixels[p][c] = '0;
			end
			OP_DRAW: begin
				top_pg = int'(row_y) >> 3;
				bot_pg = (int'(row_y) + 7) >> 3;
				if (bot_pg >= PAGES) begin
					res.hit = 1'b1;
					res.off = 1'b1;
				end else begin
					for (int k = 0; k < SPRITE_W; k++) begin
						col = int'(col_x) + k;
						if (col < COLUMNS) begin
							spread = 16'(cols[k]) << row_y[2:0];
							if ((pixels[top_pg][col] & spread[7:0]) != '0)
								res.hit = 1'b1;
							pixels[top_pg][col] = spread[7:0];
							// column straddles two pages
							if (bot_pg != top_pg) begin
								if ((pixels[bot_pg][col] & spread[15:8]) != '0)
									res.hit = 1'b1;
								pixels[bot_pg][col] = spread[15:8];
							end
						end
					end
				end
			end
			OP_READ: begin
				if (int'(pg) < PAGES && int'(col_x) < COLUMNS)
					res.data = pixels[pg][col_x];
			end
			default: begin
				// spare code: no effect, all fields zero
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		blit_outcome_t want;
		blit_outcome_t fresh;
		if (!arst_n) begin
			foreach (pixels[p, c])
				pixels[p][c] = '0;
			awaited.delete();
		end else begin
			if (result_valid) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding (coll %0b off %0b data %02h)",
						collision, off_screen, read_data));
				end else begin
					want = awaited.pop_front();
					if (collision !== want.hit)
						report_mismatch($sformatf("collision got %0b expected %0b",
							collision, want.hit));
					if (off_screen !== want.off)
						report_mismatch($sformatf("off_screen got %0b expected %0b",
							off_screen, want.off));
					if (read_data !== want.data)
						report_mismatch($sformatf("read_data got %02h expected %02h",
							read_data, want.data));
				end
			end
			if (start && !busy) begin
				blit_predict(operation, x, y, page,
					{sprite_col7, sprite_col6, sprite_col5, sprite_col4,
					 sprite_col3, sprite_col2, sprite_col1, sprite_col0}, fresh);
				awaited.push_back(fresh);
			end
		end
		outstanding = awaited.size();
	end

endmodule

// ===== tb/sprite_blit_collision_page_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_collision_page_buffer_tb
// Drives clear, draw, read and spare commands into the sprite blitter: a
// directed opening on the edges of the screen, then random commands with
// random gaps. Checking is done by sprite_blit_checker beside the block.
// ----------------------------------------------------------------------------
module sprite_blit_collision_page_buffer_tb;
	import sbc_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 900;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [X_W-1:0]  col_x;
		logic [Y_W-1:0]  row_y;
		logic [PG_W-1:0] pg;
		sprite_t         cols;
	} blit_command_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   operation = '0;
	logic [X_W-1:0]    x = '0;
	logic [Y_W-1:0]    y = '0;
	logic [PG_W-1:0]   page = '0;
	logic [BYTE_W-1:0] sprite_col0 = '0;
	logic [BYTE_W-1:0] sprite_col1 = '0;
	logic [BYTE_W-1:0] sprite_col2 = '0;
	logic [BYTE_W-1:0] sprite_col3 = '0;
	logic [BYTE_W-1:0] sprite_col4 = '0;
	logic [BYTE_W-1:0] sprite_col5 = '0;
	logic [BYTE_W-1:0] sprite_col6 = '0;
	logic [BYTE_W-1:0] sprite_col7 = '0;
	logic              busy;
	logic              result_valid;
	logic              collision;
	logic              off_screen;
	logic [BYTE_W-1:0] read_data;
	int                mismatch_count;
	int                outstanding;

	bit                steady = 1'b0;
	logic [X_W-1:0]    last_x = '0;
	logic [Y_W-1:0]    last_y = '0;

	initial begin
		forever #6 clk = ~clk;
	end

	sprite_blit_collision_page_buffer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.x            (x),
		.y            (y),
		.page         (page),
		.sprite_col0  (sprite_col0),
		.sprite_col1  (sprite_col1),
		.sprite_col2  (sprite_col2),
		.sprite_col3  (sprite_col3),
		.sprite_col4  (sprite_col4),
		.sprite_col5  (sprite_col5),
		.sprite_col6  (sprite_col6),
		.sprite_col7  (sprite_col7),
		.result_valid (result_valid),
		.collision    (collision),
		.off_screen   (off_screen),
		.read_data    (read_data)
	);

	sprite_blit_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.x              (x),
		.y              (y),
		.page           (page),
		.sprite_col0    (sprite_col0),
		.sprite_col1    (sprite_col1),
		.sprite_col2    (sprite_col2),
		.sprite_col3    (sprite_col3),
		.sprite_col4    (sprite_col4),
		.sprite_col5    (sprite_col5),
		.sprite_col6    (sprite_col6),
		.sprite_col7    (sprite_col7),
		.result_valid   (result_valid),
		.collision      (collision),
		.off_screen     (off_screen),
		.read_data      (read_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	function automatic blit_command_t make_command(
		input logic [OP_W-1:0] op,
		input int              col_x,
		input int              row_y,
		input int              pg,
		input sprite_t         cols
	);
		blit_command_t cmd;
		cmd.op    = op;
		cmd.col_x = X_W'(col_x);
		cmd.row_y = Y_W'(row_y);
		cmd.pg    = PG_W'(pg);
		cmd.cols  = cols;
		return cmd;
	endfunction

	function automatic logic [BYTE_W-1:0] random_pixels();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hff;
			2, 3: return 8'($urandom & $urandom);  // sparse, so some draws miss
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic blit_command_t random_command();
		blit_command_t cmd;
		int            pick;
		pick = $urandom_range(99);
		if ($urandom_range(3) == 0)
			cmd.col_x = X_W'($urandom_range(COLUMNS - 1, COLUMNS - SPRITE_W));
		else
			cmd.col_x = X_W'($urandom);
		cmd.row_y = Y_W'($urandom);
		cmd.pg    = PG_W'($urandom);
		foreach (cmd.cols[k])
			cmd.cols[k] = random_pixels();
		if (pick < 3) begin
			cmd.op = OP_CLEAR;
		end else if (pick < 6) begin
			cmd.op = OP_SPARE;
		end else if (pick < 52) begin
			cmd.op = OP_DRAW;
		end else begin
			cmd.op = OP_READ;
			// mostly read back under the last sprite so drawn bytes get checked
			if (pick < 85) begin
				cmd.col_x = last_x + X_W'($urandom_range(SPRITE_W - 1));
				cmd.pg    = PG_W'((last_y >> 3) + $urandom_range(1));
			end
		end
		return cmd;
	endfunction

	task automatic issue_command(input blit_command_t cmd);
		if (!steady && $urandom_range(99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= cmd.op;
		x           <= cmd.col_x;
		y           <= cmd.row_y;
		page        <= cmd.pg;
		sprite_col0 <= cmd.cols[0];
		sprite_col1 <= cmd.cols[1];
		sprite_col2 <= cmd.cols[2];
		sprite_col3 <= cmd.cols[3];
		sprite_col4 <= cmd.cols[4];
		sprite_col5 <= cmd.cols[5];
		sprite_col6 <= cmd.cols[6];
		sprite_col7 <= cmd.cols[7];
		do
			@(posedge clk);
		while (busy);
		if (cmd.op == OP_DRAW) begin
			last_x = cmd.col_x;
			last_y = cmd.row_y;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_command(make_command(OP_READ, 0, 0, 0, '0));
		issue_command(make_command(OP_DRAW, 0, 0, 0, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_READ, 0, 0, 0, '0));
		// lands on set pixels of the first sprite
		issue_command(make_command(OP_DRAW, 0, 0, 0, {SPRITE_W{8'h01}}));
		issue_command(make_command(OP_READ, 3, 0, 0, '0));
		// straddles pages 0 and 1
		issue_command(make_command(OP_DRAW, 10, 3, 0, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_READ, 10, 0, 0, '0));
		issue_command(make_command(OP_READ, 10, 0, 1, '0));
		// straddles pages 1 and 2 and hits in the upper page
		issue_command(make_command(OP_DRAW, 12, 9, 0, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_READ, 12, 0, 1, '0));
		issue_command(make_command(OP_READ, 12, 0, 2, '0));
		// clipped at the right edge on the bottom page
		issue_command(make_command(OP_DRAW, 124, 24, 0, sprite_t'({$urandom, $urandom})));
		issue_command(make_command(OP_DRAW, 127, 20, 0, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_READ, 127, 0, 3, '0));
		issue_command(make_command(OP_READ, 124, 0, 3, '0));
		// bottom passes the last page
		issue_command(make_command(OP_DRAW, 5, 25, 0, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_DRAW, 127, 31, 3, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_SPARE, 127, 31, 3, {SPRITE_W{8'hff}}));
		issue_command(make_command(OP_CLEAR, 0, 0, 0, '0));
		issue_command(make_command(OP_READ, 0, 0, 0, '0));
		issue_command(make_command(OP_READ, 127, 0, 3, '0));
		issue_command(make_command(OP_DRAW, 0, 24, 0, {SPRITE_W{8'hff}}));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 300 && n < 450);
			issue_command(random_command());
		end
		start <= 1'b0;

		// a clear can still be sweeping the store
		for (int w = 0; w < 4000 && outstanding != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (outstanding != 0)
			$display("%0d expected results never arrived", outstanding);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout");
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sbc_pkg.sv
rtl/sbc_store.sv
rtl/sbc_blit_unit.sv
rtl/sbc_seq.sv
rtl/sprite_blit_collision_page_buffer.sv
tb/sprite_blit_checker.sv
tb/sprite_blit_collision_page_buffer_tb.sv
